### sv/tcfs_pkg.sv
// Shared types and constants of the timed color fade sequencer.
// Used by tcfs_frac_div, timed_color_fade_sequencer and the bench; depends on nothing.
package tcfs_pkg;

    localparam int COLOR_W    = 8;   // color and alpha channel width
    localparam int DUR_W      = 24;  // fade and hold duration register width
    localparam int CFG_IDX_W  = 3;   // register index width
    localparam int CFG_DATA_W = 24;  // widest register
    localparam int FRAC_STEPS = COLOR_W;                 // one alpha bit per step
    localparam int FRAC_CNT_W = $clog2(FRAC_STEPS);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR   = 3'd6;

    // Overlay phase, encoded as it appears on the result port.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_FADE = 2'd1,
        PH_HOLD = 2'd2
    } phase_t;

    // Status returned by the fraction unit.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### sv/tcfs_frac_div.sv
// Digit-serial fraction unit: floor(alpha * e / d) with e < d.
// Depends on tcfs_pkg for widths and the status struct.
module tcfs_frac_div #(
    parameter int TIME_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tcfs_pkg::COLOR_W-1:0] alpha,
    input  logic [TIME_BITS-1:0]        elapsed,
    input  logic [tcfs_pkg::DUR_W-1:0]  duration,
    output tcfs_pkg::div_stat_t         stat,
    output logic [tcfs_pkg::COLOR_W-1:0] quot
);

    localparam int RW = (TIME_BITS > tcfs_pkg::DUR_W) ? TIME_BITS : tcfs_pkg::DUR_W;
    localparam int TW = RW + 2;

    logic [tcfs_pkg::COLOR_W-1:0]    a_sh_reg, a_sh_next;
    logic [RW-1:0]                   e_reg, e_next;
    logic [RW-1:0]                   d_reg, d_next;
    logic [RW-1:0]                   r_reg, r_next;
    logic [tcfs_pkg::COLOR_W-1:0]    q_reg, q_next;
    logic [tcfs_pkg::FRAC_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [TW-1:0] t_sum;
    logic [TW-1:0] t_left;
    logic [TW-1:0] d1_w;
    logic [TW-1:0] d2_w;
    logic [1:0]    q_digit;

    // Each step brings in one alpha bit times e; since the remainder stays
    // below d and e < d, the partial sum is below 3d and the quotient digit
    // is 0, 1 or 2.
    always_comb begin
        d1_w    = TW'(d_reg);
        d2_w    = {1'b0, d_reg, 1'b0};
        t_sum   = {1'b0, r_reg, 1'b0} + (a_sh_reg[tcfs_pkg::COLOR_W-1] ? TW'(e_reg) : '0);
        if (t_sum >= d2_w) begin
            t_left  = t_sum - d2_w;
            q_digit = 2'd2;
        end else if (t_sum >= d1_w) begin
            t_left  = t_sum - d1_w;
            q_digit = 2'd1;
        end else begin
            t_left  = t_sum;
            q_digit = 2'd0;
        end

        a_sh_next = a_sh_reg;
        e_next    = e_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            a_sh_next = alpha;
            e_next    = RW'(elapsed);
            d_next    = RW'(duration);
            r_next    = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            a_sh_next = {a_sh_reg[tcfs_pkg::COLOR_W-2:0], 1'b0};
            r_next    = t_left[RW-1:0];
            q_next    = {q_reg[tcfs_pkg::COLOR_W-2:0], 1'b0} + tcfs_pkg::COLOR_W'(q_digit);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == tcfs_pkg::FRAC_CNT_W'(tcfs_pkg::FRAC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_sh_reg <= a_sh_next;
        e_reg    <= e_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

### sv/timed_color_fade_sequencer.sv
// Top level of the timed color fade sequencer: phase control, registers, result beat.
// Depends on tcfs_pkg and tcfs_frac_div.

// The sequencer walks an overlay color through idle, fading and holding. A
// start beat (mode 0) clears the elapsed time and enters fading; a tick beat
// (mode 1) adds tick_amount to the elapsed time, which saturates at
// 2^TIME_BITS - 1, and moves on to holding or idle when the fade or hold
// duration is reached. Ticks while idle change nothing. Every input beat
// yields exactly one result beat carrying the current phase, the configured
// color (zero while idle) and the interpolated alpha. While fading, alpha is
// floor(color_alpha * elapsed / fade_duration), or color_alpha minus that
// value when fade_in is set; a fade_duration of zero counts as one. The
// fraction comes from a digit-serial unit that consumes one alpha bit per
// cycle. For a beat that ends in the fading phase, the fraction unit loads
// its operands at the accepting edge and takes eight steps; the control then
// sees done, moves to its finishing state and loads the result register.
// Any other beat goes straight to the finishing state. The input opens again
// when the result is loaded; loading waits while an earlier result still
// waits on m_ready. One beat is worked on at a time; the result register
// lets the next input beat be accepted while the previous result still
// waits on m_ready. The registers are read live and may be written only
// while no beat is in flight.
module timed_color_fade_sequencer #(
    parameter int TIME_BITS = 24,
    parameter int STEP_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [tcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [STEP_BITS-1:0]              s_tick_amount,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_active,
    output logic [1:0]                        m_phase,
    output logic [tcfs_pkg::COLOR_W-1:0]      m_out_red,
    output logic [tcfs_pkg::COLOR_W-1:0]      m_out_green,
    output logic [tcfs_pkg::COLOR_W-1:0]      m_out_blue,
    output logic [tcfs_pkg::COLOR_W-1:0]      m_out_alpha
);

    localparam int CMP_W = (TIME_BITS > tcfs_pkg::DUR_W) ? TIME_BITS : tcfs_pkg::DUR_W;
    localparam int SUM_W = ((TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS) + 1;

    // Sequencer control: wait for a beat, run the fraction unit, load the result.
    typedef enum logic [2:0] {
        ST_WAIT = 3'b001,
        ST_CALC = 3'b010,
        ST_FIN  = 3'b100
    } ctl_state_t;

    // Configuration registers.
    logic [tcfs_pkg::COLOR_W-1:0] red_reg;
    logic [tcfs_pkg::COLOR_W-1:0] green_reg;
    logic [tcfs_pkg::COLOR_W-1:0] blue_reg;
    logic [tcfs_pkg::COLOR_W-1:0] alpha_reg;
    logic [tcfs_pkg::DUR_W-1:0]   fade_reg;
    logic [tcfs_pkg::DUR_W-1:0]   hold_reg;
    logic                         dir_reg;

    // Architectural state.
    tcfs_pkg::phase_t     phase_reg, phase_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    ctl_state_t           st_reg, st_next;
    logic [tcfs_pkg::COLOR_W-1:0] alpha_lat_reg;

    // Result register.
    logic                         m_valid_reg;
    tcfs_pkg::phase_t             m_phase_reg;
    logic [tcfs_pkg::COLOR_W-1:0] m_red_reg, m_green_reg, m_blue_reg, m_alpha_reg;

    logic                         in_beat;
    logic                         load_out;
    logic [tcfs_pkg::DUR_W-1:0]   dur_eff;
    logic [SUM_W-1:0]             tick_sum;
    logic [TIME_BITS-1:0]         tick_sat;
    logic                         div_start;
    tcfs_pkg::div_stat_t          div_stat;
    logic [tcfs_pkg::COLOR_W-1:0] div_quot;
    logic [tcfs_pkg::COLOR_W-1:0] alpha_res;

    assign s_ready  = (st_reg == ST_WAIT);
    assign in_beat  = s_valid && s_ready;
    assign load_out = (st_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // A zero fade duration behaves as one tick.
    assign dur_eff = (fade_reg == '0) ? tcfs_pkg::DUR_W'(1) : fade_reg;

    // Phase and elapsed-time update for the beat being accepted.
    always_comb begin
        tick_sum     = SUM_W'(elapsed_reg) + SUM_W'(s_tick_amount);
        tick_sat     = (|tick_sum[SUM_W-1:TIME_BITS]) ? '1 : tick_sum[TIME_BITS-1:0];
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        if (!s_mode) begin
            phase_next   = tcfs_pkg::PH_FADE;
            elapsed_next = '0;
        end else if (phase_reg == tcfs_pkg::PH_FADE) begin
            elapsed_next = tick_sat;
            if (CMP_W'(tick_sat) >= CMP_W'(dur_eff)) begin
                elapsed_next = '0;
                phase_next   = (hold_reg != '0) ? tcfs_pkg::PH_HOLD : tcfs_pkg::PH_IDLE;
            end
        end else if (phase_reg == tcfs_pkg::PH_HOLD) begin
            elapsed_next = tick_sat;
            if (CMP_W'(tick_sat) >= CMP_W'(hold_reg)) begin
                elapsed_next = '0;
                phase_next   = tcfs_pkg::PH_IDLE;
            end
        end
    end

    // The fraction unit starts on the beat itself with the updated elapsed time.
    assign div_start = in_beat && (phase_next == tcfs_pkg::PH_FADE);

    tcfs_frac_div #(
        .TIME_BITS(TIME_BITS)
    ) u_frac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .alpha   (alpha_reg),
        .elapsed (elapsed_next),
        .duration(dur_eff),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_WAIT: begin
                if (in_beat) begin
                    st_next = div_start ? ST_CALC : ST_FIN;
                end
            end
            ST_CALC: begin
                if (div_stat.done) begin
                    st_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (load_out) begin
                    st_next = ST_WAIT;
                end
            end
            default: begin
                st_next = ST_WAIT;
            end
        endcase
    end

    // The quotient is held in the fraction unit until the next start.
    always_comb begin
        case (phase_reg)
            tcfs_pkg::PH_FADE: alpha_res = dir_reg ? (alpha_lat_reg - div_quot) : div_quot;
            tcfs_pkg::PH_HOLD: alpha_res = alpha_lat_reg;
            default:           alpha_res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
            alpha_reg   <= '0;
            fade_reg    <= tcfs_pkg::DUR_W'(1);
            hold_reg    <= '0;
            dir_reg     <= 1'b0;
            phase_reg   <= tcfs_pkg::PH_IDLE;
            elapsed_reg <= '0;
            st_reg      <= ST_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tcfs_pkg::CFG_RED:   red_reg   <= cfg_wdata[tcfs_pkg::COLOR_W-1:0];
                    tcfs_pkg::CFG_GREEN: green_reg <= cfg_wdata[tcfs_pkg::COLOR_W-1:0];
                    tcfs_pkg::CFG_BLUE:  blue_reg  <= cfg_wdata[tcfs_pkg::COLOR_W-1:0];
                    tcfs_pkg::CFG_ALPHA: alpha_reg <= cfg_wdata[tcfs_pkg::COLOR_W-1:0];
                    tcfs_pkg::CFG_FADE:  fade_reg  <= cfg_wdata[tcfs_pkg::DUR_W-1:0];
                    tcfs_pkg::CFG_HOLD:  hold_reg  <= cfg_wdata[tcfs_pkg::DUR_W-1:0];
                    tcfs_pkg::CFG_DIR:   dir_reg   <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (in_beat) begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
            end
            st_reg <= st_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            alpha_lat_reg <= alpha_reg;
        end
        if (load_out) begin
            m_phase_reg <= phase_reg;
            m_alpha_reg <= alpha_res;
            if (phase_reg == tcfs_pkg::PH_IDLE) begin
                m_red_reg   <= '0;
                m_green_reg <= '0;
                m_blue_reg  <= '0;
            end else begin
                m_red_reg   <= red_reg;
                m_green_reg <= green_reg;
                m_blue_reg  <= blue_reg;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_phase     = m_phase_reg;
    assign m_active    = (m_phase_reg != tcfs_pkg::PH_IDLE);
    assign m_out_red   = m_red_reg;
    assign m_out_green = m_green_reg;
    assign m_out_blue  = m_blue_reg;
    assign m_out_alpha = m_alpha_reg;

    // Elapsed time is always cleared on the way back to idle.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == tcfs_pkg::PH_IDLE) |-> (elapsed_reg == '0))
        else $error("elapsed time not cleared in idle");

    // The fraction unit only runs while the control waits for it.
    a_busy_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (st_reg == ST_CALC))
        else $error("fraction unit busy outside the calculation state");

    // The fade fraction never exceeds the full alpha it scales.
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((st_reg == ST_CALC) && div_stat.done) |-> (div_quot <= alpha_lat_reg))
        else $error("fade fraction above full alpha");

    // A result only appears after the finishing state.
    a_out_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(st_reg == ST_FIN))
        else $error("result raised outside the finishing state");

    // An idle result carries no color.
    a_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_active) |->
            (m_out_red == '0 && m_out_green == '0 && m_out_blue == '0 && m_out_alpha == '0))
        else $error("idle result carries color");

endmodule

### sim/tb_timed_color_fade_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for timed_color_fade_sequencer: reset defaults, directed fades, live
// register changes, elapsed-time saturation and random tick sequences, with every result
// beat checked against an in-bench phase and alpha predictor. Depends on tcfs_pkg and the RTL.
module tb_timed_color_fade_sequencer;

    localparam int TIME_BITS     = 24;
    localparam int STEP_BITS     = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    // Covers any beat in flight, also one that ends in the fading phase.
    localparam int SETTLE_CYCLES = 14;
    localparam logic [TIME_BITS-1:0] ELAPSED_MAX = '1;

    // One result beat as the block presents it.
    typedef struct packed {
        logic                         active;
        logic [1:0]                   phase;
        logic [tcfs_pkg::COLOR_W-1:0] red;
        logic [tcfs_pkg::COLOR_W-1:0] green;
        logic [tcfs_pkg::COLOR_W-1:0] blue;
        logic [tcfs_pkg::COLOR_W-1:0] alpha;
    } overlay_t;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [tcfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tcfs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_mode = 1'b0;
    logic [STEP_BITS-1:0]            s_tick_amount = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_active;
    logic [1:0]                      m_phase;
    logic [tcfs_pkg::COLOR_W-1:0]    m_out_red;
    logic [tcfs_pkg::COLOR_W-1:0]    m_out_green;
    logic [tcfs_pkg::COLOR_W-1:0]    m_out_blue;
    logic [tcfs_pkg::COLOR_W-1:0]    m_out_alpha;

    timed_color_fade_sequencer #(
        .TIME_BITS(TIME_BITS),
        .STEP_BITS(STEP_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_tick_amount(s_tick_amount),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_active     (m_active),
        .m_phase      (m_phase),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the registers, starting from their reset values.
    logic [tcfs_pkg::COLOR_W-1:0] reg_red     = '0;
    logic [tcfs_pkg::COLOR_W-1:0] reg_green   = '0;
    logic [tcfs_pkg::COLOR_W-1:0] reg_blue    = '0;
    logic [tcfs_pkg::COLOR_W-1:0] reg_alpha   = '0;
    logic [tcfs_pkg::DUR_W-1:0]   reg_fade    = tcfs_pkg::DUR_W'(1);
    logic [tcfs_pkg::DUR_W-1:0]   reg_hold    = '0;
    logic                         reg_fade_in = 1'b0;

    // Predictor copy of the sequencer state.
    tcfs_pkg::phase_t     seq_phase   = tcfs_pkg::PH_IDLE;
    logic [TIME_BITS-1:0] seq_elapsed = '0;

    overlay_t expected_overlays[$];
    int       errors      = 0;
    int       cycle_count = 0;
    int       stall_left  = 0;
    // When set, neither side idles, so beats run back to back.
    bit       calm        = 1'b0;

    // Applies one accepted beat to the predicted state and returns the overlay the
    // block must show afterwards.
    function automatic overlay_t advance_overlay(input logic mode,
                                                 input logic [STEP_BITS-1:0] ticks);
        logic [63:0] span;
        logic [63:0] sum;
        logic [63:0] upto;
        logic [63:0] frac;
        overlay_t    res;
        // A zero fade duration behaves like one tick.
        span = (reg_fade == '0) ? 64'd1 : 64'(reg_fade);
        if (!mode) begin
            // A start restarts the fade from zero, even in the middle of one.
            seq_elapsed = '0;
            seq_phase   = tcfs_pkg::PH_FADE;
        end else if (seq_phase != tcfs_pkg::PH_IDLE) begin
            // Ticks while idle change nothing; otherwise the elapsed time saturates.
            sum = 64'(seq_elapsed) + 64'(ticks);
            seq_elapsed = (sum > 64'(ELAPSED_MAX)) ? ELAPSED_MAX : sum[TIME_BITS-1:0];
            if (seq_phase == tcfs_pkg::PH_FADE) begin
                if (64'(seq_elapsed) >= span) begin
                    seq_elapsed = '0;
                    seq_phase   = (reg_hold != '0) ? tcfs_pkg::PH_HOLD : tcfs_pkg::PH_IDLE;
                end
            end else if (64'(seq_elapsed) >= 64'(reg_hold)) begin
                seq_elapsed = '0;
                seq_phase   = tcfs_pkg::PH_IDLE;
            end
        end
        res = '0;
        if (seq_phase != tcfs_pkg::PH_IDLE) begin
            res.active = 1'b1;
            res.phase  = seq_phase;
            res.red    = reg_red;
            res.green  = reg_green;
            res.blue   = reg_blue;
            if (seq_phase == tcfs_pkg::PH_HOLD) begin
                res.alpha = reg_alpha;
            end else begin
                // The elapsed time may exceed a fade duration shortened mid fade.
                upto = (64'(seq_elapsed) < span) ? 64'(seq_elapsed) : span;
                frac = (64'(reg_alpha) * upto) / span;
                res.alpha = reg_fade_in ? reg_alpha - frac[tcfs_pkg::COLOR_W-1:0]
                                        : frac[tcfs_pkg::COLOR_W-1:0];
            end
        end
        return res;
    endfunction

    // Idle lengths: mostly none, often a short one, now and then a long stretch.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Tick amounts are mostly scaled to the running phase so that random sequences
    // walk through fading and holding; the rest cover the whole field.
    function automatic logic [STEP_BITS-1:0] pick_ticks();
        logic [63:0] limit;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 8)  return STEP_BITS'($urandom_range(0, 65535));
        if (r < 12) return '0;
        if (r < 15) return '1;
        limit = (seq_phase == tcfs_pkg::PH_HOLD) ? 64'(reg_hold) : 64'(reg_fade);
        limit = limit / 3 + 1;
        if (limit > 64'd65535) limit = 64'd65535;
        return STEP_BITS'($urandom_range(0, int'(limit)));
    endfunction

    // Register values lean on the extremes. Narrow registers get noise in their
    // upper data bits, which the block has to drop.
    function automatic logic [tcfs_pkg::CFG_DATA_W-1:0] pick_register_value(
            input logic [tcfs_pkg::CFG_IDX_W-1:0] idx);
        logic [31:0]                     raw;
        logic [tcfs_pkg::CFG_DATA_W-1:0] noise;
        int                              r;
        raw   = $urandom();
        noise = raw[tcfs_pkg::CFG_DATA_W-1:0];
        r     = $urandom_range(0, 99);
        case (idx)
            tcfs_pkg::CFG_FADE, tcfs_pkg::CFG_HOLD: begin
                if (r < 10) return '0;
                if (r < 15) return '1;
                if (r < 22) return tcfs_pkg::CFG_DATA_W'(1);
                if (r < 85) return tcfs_pkg::CFG_DATA_W'($urandom_range(1, 64));
                return tcfs_pkg::CFG_DATA_W'($urandom_range(65, 100000));
            end
            tcfs_pkg::CFG_DIR: begin
                return noise;
            end
            default: begin
                if (r < 15) begin
                    return {noise[tcfs_pkg::CFG_DATA_W-1:tcfs_pkg::COLOR_W],
                            {tcfs_pkg::COLOR_W{1'b0}}};
                end
                if (r < 30) begin
                    return {noise[tcfs_pkg::CFG_DATA_W-1:tcfs_pkg::COLOR_W],
                            {tcfs_pkg::COLOR_W{1'b1}}};
                end
                return noise;
            end
        endcase
    endfunction

    // Writes one register and mirrors it into the predictor. Callers make sure no
    // beat is in flight.
    task automatic write_register(input logic [tcfs_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tcfs_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            tcfs_pkg::CFG_RED:   reg_red     = value[tcfs_pkg::COLOR_W-1:0];
            tcfs_pkg::CFG_GREEN: reg_green   = value[tcfs_pkg::COLOR_W-1:0];
            tcfs_pkg::CFG_BLUE:  reg_blue    = value[tcfs_pkg::COLOR_W-1:0];
            tcfs_pkg::CFG_ALPHA: reg_alpha   = value[tcfs_pkg::COLOR_W-1:0];
            tcfs_pkg::CFG_FADE:  reg_fade    = value[tcfs_pkg::DUR_W-1:0];
            tcfs_pkg::CFG_HOLD:  reg_hold    = value[tcfs_pkg::DUR_W-1:0];
            tcfs_pkg::CFG_DIR:   reg_fade_in = value[0];
            default:             ;
        endcase
    endtask

    // Sends one input beat after an optional gap. On return valid is still high at
    // the acceptance step, so the caller either sends the next beat at once or
    // lowers valid through drain_results.
    task automatic send_beat(input logic mode, input logic [STEP_BITS-1:0] ticks);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_tick_amount <= ticks;
        do @(posedge aclk); while (!s_ready);
        expected_overlays.push_back(advance_overlay(mode, ticks));
    endtask

    // Stops the sender until every expected result has come back and the block
    // has had time to settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_overlays.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: random back-pressure, with calm stretches where m_ready stays high.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left <= pick_gap();
            end
        end
    end

    // Every accepted result beat is matched against the oldest expectation.
    always @(posedge aclk) begin
        overlay_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_overlays.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual phase %0d alpha %0d",
                         $time, m_phase, m_out_alpha);
                errors++;
            end else begin
                want = expected_overlays.pop_front();
                compare_field("active", 32'(want.active), 32'(m_active));
                compare_field("phase", 32'(want.phase), 32'(m_phase));
                compare_field("out_red", 32'(want.red), 32'(m_out_red));
                compare_field("out_green", 32'(want.green), 32'(m_out_green));
                compare_field("out_blue", 32'(want.blue), 32'(m_out_blue));
                compare_field("out_alpha", 32'(want.alpha), 32'(m_out_alpha));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Registers at their reset values: a tick while idle is ignored, and with a
    // one-tick fade and no hold a single tick ends the fade.
    task automatic test_reset_defaults();
        send_beat(1'b1, 16'd1);
        send_beat(1'b0, '0);
        send_beat(1'b1, '0);
        send_beat(1'b1, 16'd1);
        drain_results();
    endtask

    // A full fade out, hold and return to idle, restarts, oversized ticks, a fade in,
    // and a zero fade duration that behaves as one tick.
    task automatic test_directed_fades();
        write_register(tcfs_pkg::CFG_RED, 24'h0000FF);
        write_register(tcfs_pkg::CFG_GREEN, 24'h000000);
        write_register(tcfs_pkg::CFG_BLUE, 24'h0000A5);
        write_register(tcfs_pkg::CFG_ALPHA, 24'h0000FF);
        write_register(tcfs_pkg::CFG_FADE, 24'd10);
        write_register(tcfs_pkg::CFG_HOLD, 24'd5);
        write_register(tcfs_pkg::CFG_DIR, 24'd0);
        send_beat(1'b0, '0);
        send_beat(1'b1, 16'd0);
        send_beat(1'b1, 16'd3);
        send_beat(1'b1, 16'd6);
        send_beat(1'b1, 16'd1);
        send_beat(1'b1, 16'd2);
        send_beat(1'b1, 16'd3);
        send_beat(1'b1, 16'd4);
        send_beat(1'b0, 16'hFFFF);
        send_beat(1'b1, 16'd4);
        send_beat(1'b0, '0);
        send_beat(1'b1, 16'hFFFF);
        send_beat(1'b1, 16'hFFFF);
        drain_results();
        write_register(tcfs_pkg::CFG_DIR, 24'd1);
        send_beat(1'b0, '0);
        send_beat(1'b1, 16'd5);
        send_beat(1'b1, 16'd4);
        send_beat(1'b1, 16'd1);
        drain_results();
        write_register(tcfs_pkg::CFG_FADE, 24'd0);
        send_beat(1'b0, '0);
        send_beat(1'b1, 16'd0);
        send_beat(1'b1, 16'd1);
        send_beat(1'b1, 16'd5);
        drain_results();
    endtask

    // Registers are read live: a fade duration shortened below the elapsed time ends
    // the fade on the next tick, even a zero one, and new colors show at once.
    task automatic test_live_registers();
        write_register(tcfs_pkg::CFG_FADE, 24'd100);
        write_register(tcfs_pkg::CFG_HOLD, 24'd0);
        write_register(tcfs_pkg::CFG_DIR, 24'd0);
        write_register(tcfs_pkg::CFG_ALPHA, 24'd200);
        send_beat(1'b0, '0);
        send_beat(1'b1, 16'd60);
        drain_results();
        write_register(tcfs_pkg::CFG_FADE, 24'd20);
        send_beat(1'b1, 16'd0);
        send_beat(1'b0, '0);
        send_beat(1'b1, 16'd10);
        drain_results();
        write_register(tcfs_pkg::CFG_HOLD, 24'd7);
        write_register(tcfs_pkg::CFG_RED, 24'h000012);
        send_beat(1'b1, 16'd10);
        drain_results();
        write_register(tcfs_pkg::CFG_GREEN, 24'hFFFFFF);
        write_register(tcfs_pkg::CFG_ALPHA, 24'hFFFF00);
        send_beat(1'b1, 16'd3);
        send_beat(1'b1, 16'd4);
        drain_results();
    endtask

    // With both durations at their maximum, 256 full ticks leave the elapsed time
    // just short of it; the next one saturates the sum, which ends the phase.
    task automatic test_elapsed_saturation();
        write_register(tcfs_pkg::CFG_FADE, 24'hFFFFFF);
        write_register(tcfs_pkg::CFG_HOLD, 24'hFFFFFF);
        write_register(tcfs_pkg::CFG_ALPHA, 24'h0000FF);
        write_register(tcfs_pkg::CFG_DIR, 24'hFFFFFF);
        send_beat(1'b0, '0);
        repeat (257) send_beat(1'b1, 16'hFFFF);
        repeat (257) send_beat(1'b1, 16'hFFFF);
        drain_results();
    endtask

    // Rounds of random register settings, the first two at all minimums and all
    // maximums. Within a round, starts are sent mostly while idle and ticks mostly
    // while not idle; once in a while the sender drains and rewrites a register.
    task automatic test_random_sequences();
        logic [tcfs_pkg::CFG_DATA_W-1:0] value;
        logic [tcfs_pkg::CFG_IDX_W-1:0]  idx;
        logic                            mode;
        int                              counted;
        int                              r;
        for (int round = 0; round < 7; round++) begin
            calm = (round % 3 == 2);
            for (int i = int'(tcfs_pkg::CFG_RED); i <= int'(tcfs_pkg::CFG_DIR); i++) begin
                idx = tcfs_pkg::CFG_IDX_W'(i);
                case (round)
                    0:       value = '0;
                    1:       value = '1;
                    default: value = pick_register_value(idx);
                endcase
                write_register(idx, value);
            end
            counted = 0;
            while (counted < 130) begin
                r = $urandom_range(0, 99);
                if (seq_phase == tcfs_pkg::PH_IDLE) begin
                    mode = (r < 85) ? 1'b0 : 1'b1;
                end else begin
                    mode = (r < 6) ? 1'b0 : 1'b1;
                end
                // Ticks while idle are ignored by the block and do not count.
                if (!(mode && seq_phase == tcfs_pkg::PH_IDLE)) counted++;
                send_beat(mode, pick_ticks());
                if ($urandom_range(0, 99) < 2) begin
                    drain_results();
                    idx = tcfs_pkg::CFG_IDX_W'($urandom_range(int'(tcfs_pkg::CFG_RED),
                                                              int'(tcfs_pkg::CFG_DIR)));
                    write_register(idx, pick_register_value(idx));
                end
            end
            drain_results();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_fades();
        test_live_registers();
        test_elapsed_saturation();
        test_random_sequences();
        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
sv/tcfs_pkg.sv
sv/tcfs_frac_div.sv
sv/timed_color_fade_sequencer.sv
sim/tb_timed_color_fade_sequencer.sv
